### rtl/rlzd_pkg.sv
// rlzd_pkg: shared types, constants and the preset dictionary text
// for the compressed rtf (lzfu) decompressor
// no dependencies
`default_nettype none

package rlzd_pkg;

    localparam int DICT_SIZE   = 4096;
    localparam int DICT_AW     = $clog2(DICT_SIZE);
    localparam int FILL_W      = DICT_AW + 1;
    localparam int COUNT_WIDTH = 24;
    localparam int LIMIT_W     = 24;
    localparam int PRESET_LEN  = 207;
    localparam int PRESET_AW   = $clog2(PRESET_LEN);
    localparam int LEN_W       = 5;
    localparam int FLAGS_W     = 4;
    localparam int FLAGS_PER_CTRL = 8;
    localparam int LEN_BIAS    = 2;
    localparam logic [7:0] LEN_MASK = 8'h0F;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

    localparam logic [1:0] STATUS_BYTE  = 2'd0;
    localparam logic [1:0] STATUS_LIMIT = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COPY_RD,
        ST_COPY_WR
    } state_t;

    typedef enum logic [1:0] {
        EMIT_LITERAL,
        EMIT_COPY,
        EMIT_LIMIT,
        EMIT_ZERO
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      dict_write;
        logic      advance_flag;
        logic      load_flags;
        logic      store_high;
        logic      start_copy;
        logic      clear_phase;
        logic      copy_read;
        logic      set_halt;
    } cmd_t;

    typedef struct packed {
        logic halted;
        logic limit_zero;
        logic flags_empty;
        logic flag_bit;
        logic ref_phase;
        logic item_last;
        logic at_limit;
        logic copy_final;
        logic out_free;
    } sts_t;

    localparam logic [7:0] PRESET_ROM [0:PRESET_LEN-1] = '{
        8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66, 8'h31, 8'h5C, 8'h61,
        8'h6E, 8'h73, 8'h69, 8'h5C, 8'h6D, 8'h61, 8'h63, 8'h5C,
        8'h64, 8'h65, 8'h66, 8'h66, 8'h30, 8'h5C, 8'h64, 8'h65,
        8'h66, 8'h74, 8'h61, 8'h62, 8'h37, 8'h32, 8'h30, 8'h7B,
        8'h5C, 8'h66, 8'h6F, 8'h6E, 8'h74, 8'h74, 8'h62, 8'h6C,
        8'h3B, 8'h7D, 8'h7B, 8'h5C, 8'h66, 8'h30, 8'h5C, 8'h66,
        8'h6E, 8'h69, 8'h6C, 8'h20, 8'h5C, 8'h66, 8'h72, 8'h6F,
        8'h6D, 8'h61, 8'h6E, 8'h20, 8'h5C, 8'h66, 8'h73, 8'h77,
        8'h69, 8'h73, 8'h73, 8'h20, 8'h5C, 8'h66, 8'h6D, 8'h6F,
        8'h64, 8'h65, 8'h72, 8'h6E, 8'h20, 8'h5C, 8'h66, 8'h73,
        8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h20, 8'h5C, 8'h66,
        8'h64, 8'h65, 8'h63, 8'h6F, 8'h72, 8'h20, 8'h4D, 8'h53,
        8'h20, 8'h53, 8'h61, 8'h6E, 8'h73, 8'h20, 8'h53, 8'h65,
        8'h72, 8'h69, 8'h66, 8'h53, 8'h79, 8'h6D, 8'h62, 8'h6F,
        8'h6C, 8'h41, 8'h72, 8'h69, 8'h61, 8'h6C, 8'h54, 8'h69,
        8'h6D, 8'h65, 8'h73, 8'h20, 8'h4E, 8'h65, 8'h77, 8'h20,
        8'h52, 8'h6F, 8'h6D, 8'h61, 8'h6E, 8'h43, 8'h6F, 8'h75,
        8'h72, 8'h69, 8'h65, 8'h72, 8'h7B, 8'h5C, 8'h63, 8'h6F,
        8'h6C, 8'h6F, 8'h72, 8'h74, 8'h62, 8'h6C, 8'h5C, 8'h72,
        8'h65, 8'h64, 8'h30, 8'h5C, 8'h67, 8'h72, 8'h65, 8'h65,
        8'h6E, 8'h30, 8'h5C, 8'h62, 8'h6C, 8'h75, 8'h65, 8'h30,
        8'h0D, 8'h0A, 8'h5C, 8'h70, 8'h61, 8'h72, 8'h20, 8'h5C,
        8'h70, 8'h61, 8'h72, 8'h64, 8'h5C, 8'h70, 8'h6C, 8'h61,
        8'h69, 8'h6E, 8'h5C, 8'h66, 8'h30, 8'h5C, 8'h66, 8'h73,
        8'h32, 8'h30, 8'h5C, 8'h62, 8'h5C, 8'h69, 8'h5C, 8'h75,
        8'h5C, 8'h74, 8'h61, 8'h62, 8'h5C, 8'h74, 8'h78
    };

    function automatic logic [7:0] preset_byte(input logic [DICT_AW-1:0] addr);
        logic [7:0] value;
        value = 8'h00;
        if (addr < DICT_AW'(PRESET_LEN))
        begin
            value = PRESET_ROM[addr[PRESET_AW-1:0]];
        end
        return value;
    endfunction

endpackage

`default_nettype wire

### rtl/rlzd_ram.sv
// rlzd_ram: generic single write port, single read port ram
// read data is registered and held while read enable is low; no dependencies
`default_nettype none

module rlzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/rlzd_ctrl.sv
// rlzd_ctrl: sequencing state machine of the decompressor
// depends on rlzd_pkg; drives commands to rlzd_datapath from its status
`default_nettype none

module rlzd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire rlzd_pkg::sts_t sts,
    output rlzd_pkg::cmd_t     cmd
);

    rlzd_pkg::state_t state_reg;
    rlzd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlzd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlzd_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = rlzd_pkg::ST_DECODE;
                end
            end
            rlzd_pkg::ST_DECODE:
            begin
                if (sts.halted)
                begin
                    state_next = rlzd_pkg::ST_IDLE;
                end
                else if (sts.limit_zero)
                begin
                    if (sts.out_free)
                    begin
                        state_next = rlzd_pkg::ST_IDLE;
                    end
                end
                else if (sts.flags_empty)
                begin
                    state_next = rlzd_pkg::ST_IDLE;
                end
                else if (!sts.flag_bit)
                begin
                    if (sts.out_free)
                    begin
                        state_next = rlzd_pkg::ST_IDLE;
                    end
                end
                else if (!sts.ref_phase || sts.item_last)
                begin
                    state_next = rlzd_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rlzd_pkg::ST_COPY_RD;
                end
            end
            rlzd_pkg::ST_COPY_RD:
            begin
                state_next = rlzd_pkg::ST_COPY_WR;
            end
            rlzd_pkg::ST_COPY_WR:
            begin
                if (sts.out_free)
                begin
                    if (sts.at_limit || sts.copy_final)
                    begin
                        state_next = rlzd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = rlzd_pkg::ST_COPY_RD;
                    end
                end
            end
            default:
            begin
                state_next = rlzd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.emit_sel = rlzd_pkg::EMIT_LITERAL;
        item_stall = (state_reg != rlzd_pkg::ST_IDLE);
        case (state_reg)
            rlzd_pkg::ST_IDLE:
            begin
                cmd.accept = item_valid;
            end
            rlzd_pkg::ST_DECODE:
            begin
                if (sts.halted)
                begin
                    cmd = '0;
                end
                else if (sts.limit_zero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = rlzd_pkg::EMIT_ZERO;
                        cmd.emit_last = 1'b1;
                        cmd.set_halt  = 1'b1;
                    end
                end
                else if (sts.flags_empty)
                begin
                    cmd.load_flags = 1'b1;
                    cmd.set_halt   = sts.item_last;
                end
                else if (!sts.flag_bit)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        if (sts.at_limit)
                        begin
                            cmd.emit_sel = rlzd_pkg::EMIT_LIMIT;
                            cmd.set_halt = 1'b1;
                        end
                        else
                        begin
                            cmd.emit_sel     = rlzd_pkg::EMIT_LITERAL;
                            cmd.dict_write   = 1'b1;
                            cmd.advance_flag = 1'b1;
                            cmd.set_halt     = sts.item_last;
                        end
                    end
                end
                else if (!sts.ref_phase)
                begin
                    cmd.store_high = 1'b1;
                    cmd.set_halt   = sts.item_last;
                end
                else if (sts.item_last)
                begin
                    cmd.clear_phase = 1'b1;
                    cmd.set_halt    = 1'b1;
                end
                else
                begin
                    cmd.clear_phase = 1'b1;
                    cmd.start_copy  = 1'b1;
                end
            end
            rlzd_pkg::ST_COPY_RD:
            begin
                cmd.copy_read = 1'b1;
            end
            rlzd_pkg::ST_COPY_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.at_limit)
                    begin
                        cmd.emit_sel  = rlzd_pkg::EMIT_LIMIT;
                        cmd.emit_last = 1'b1;
                        cmd.set_halt  = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_sel     = rlzd_pkg::EMIT_COPY;
                        cmd.emit_last    = sts.copy_final;
                        cmd.dict_write   = 1'b1;
                        cmd.advance_flag = sts.copy_final;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/rlzd_datapath.sv
// rlzd_datapath: dictionary, pointers, flag state, counters and result register
// depends on rlzd_pkg and rlzd_ram; driven by rlzd_ctrl commands
`default_nettype none

module rlzd_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rlzd_pkg::cmd_t                cmd,
    output rlzd_pkg::sts_t                     sts,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          stream_start,
    input  wire logic                          stream_end,
    input  wire logic                          cfg_valid,
    input  wire logic [rlzd_pkg::LIMIT_W-1:0]  cfg_data,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [7:0]                         out_byte,
    output logic [1:0]                         status,
    output logic                               run_last
);

    localparam int AW    = rlzd_pkg::DICT_AW;
    localparam int FW    = rlzd_pkg::FILL_W;
    localparam int CW    = rlzd_pkg::COUNT_WIDTH;
    localparam int LW    = rlzd_pkg::LIMIT_W;
    localparam int CMP_W = (CW > LW) ? CW : LW;
    localparam logic [CMP_W-1:0] CAP = CMP_W'({CW{1'b1}});
    localparam logic [AW-1:0] WP_RESET = AW'(rlzd_pkg::PRESET_LEN);
    localparam logic [FW-1:0] FILL_FULL = FW'(rlzd_pkg::DICT_SIZE);

    logic [LW-1:0]                   limit_reg;
    logic [AW-1:0]                   wp_reg;
    logic [7:0]                      flag_bits_reg;
    logic [rlzd_pkg::FLAGS_W-1:0]    flags_left_reg;
    logic [7:0]                      ref_high_reg;
    logic                            phase_reg;
    logic [CW-1:0]                   count_reg;
    logic                            halted_reg;
    logic [FW-1:0]                   fill_reg;
    logic [rlzd_pkg::LEN_W-1:0]      copy_left_reg;
    logic                            result_valid_reg;

    logic [7:0]                      byte_reg;
    logic                            last_reg;
    logic [AW-1:0]                   copy_addr_reg;
    logic                            hit_reg;
    logic [7:0]                      preset_reg;
    logic [7:0]                      out_byte_reg;
    logic [1:0]                      status_reg;
    logic                            run_last_reg;

    logic                            restart;
    logic                            out_free;
    logic [CMP_W-1:0]                limit_ext;
    logic [CMP_W-1:0]                eff_limit;
    logic [7:0]                      ram_rdata;
    logic [7:0]                      copy_data;
    logic [7:0]                      wdata;
    logic [AW-1:0]                   rel_addr;
    logic [7:0]                      emit_byte;
    logic [1:0]                      emit_status;

    assign restart   = cmd.accept && stream_start;
    assign out_free  = !result_valid_reg || !result_stall;
    assign limit_ext = CMP_W'(limit_reg);
    assign eff_limit = (limit_ext < CAP) ? limit_ext : CAP;
    assign copy_data = hit_reg ? ram_rdata : preset_reg;
    assign wdata     = (cmd.emit_sel == rlzd_pkg::EMIT_COPY) ? copy_data : byte_reg;
    assign rel_addr  = copy_addr_reg - WP_RESET;

    always_comb
    begin
        sts.halted      = halted_reg;
        sts.limit_zero  = (limit_reg == '0);
        sts.flags_empty = (flags_left_reg == '0);
        sts.flag_bit    = flag_bits_reg[0];
        sts.ref_phase   = phase_reg;
        sts.item_last   = last_reg;
        sts.at_limit    = (CMP_W'(count_reg) >= eff_limit);
        sts.copy_final  = (copy_left_reg == rlzd_pkg::LEN_W'(1));
        sts.out_free    = out_free;
    end

    always_comb
    begin
        case (cmd.emit_sel)
            rlzd_pkg::EMIT_LITERAL:
            begin
                emit_byte   = byte_reg;
                emit_status = rlzd_pkg::STATUS_BYTE;
            end
            rlzd_pkg::EMIT_COPY:
            begin
                emit_byte   = copy_data;
                emit_status = rlzd_pkg::STATUS_BYTE;
            end
            rlzd_pkg::EMIT_ZERO:
            begin
                emit_byte   = 8'h00;
                emit_status = rlzd_pkg::STATUS_ZERO;
            end
            default:
            begin
                emit_byte   = 8'h00;
                emit_status = rlzd_pkg::STATUS_LIMIT;
            end
        endcase
    end

    rlzd_ram #(
        .WIDTH (8),
        .DEPTH (rlzd_pkg::DICT_SIZE)
    ) u_dict (
        .clk   (clk),
        .we    (cmd.dict_write),
        .waddr (wp_reg),
        .wdata (wdata),
        .re    (cmd.copy_read),
        .raddr (copy_addr_reg),
        .rdata (ram_rdata)
    );

    // control and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg        <= rlzd_pkg::LIMIT_RESET;
            wp_reg           <= WP_RESET;
            flag_bits_reg    <= '0;
            flags_left_reg   <= '0;
            ref_high_reg     <= '0;
            phase_reg        <= 1'b0;
            count_reg        <= '0;
            halted_reg       <= 1'b0;
            fill_reg         <= '0;
            copy_left_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (restart)
            begin
                wp_reg         <= WP_RESET;
                flag_bits_reg  <= '0;
                flags_left_reg <= '0;
                ref_high_reg   <= '0;
                phase_reg      <= 1'b0;
                count_reg      <= '0;
                halted_reg     <= 1'b0;
                fill_reg       <= '0;
            end
            if (cmd.set_halt)
            begin
                halted_reg <= 1'b1;
            end
            if (cmd.load_flags)
            begin
                flag_bits_reg  <= byte_reg;
                flags_left_reg <= rlzd_pkg::FLAGS_W'(rlzd_pkg::FLAGS_PER_CTRL);
            end
            if (cmd.advance_flag)
            begin
                flag_bits_reg <= {1'b0, flag_bits_reg[7:1]};
                if (flags_left_reg != '0)
                begin
                    flags_left_reg <= flags_left_reg - rlzd_pkg::FLAGS_W'(1);
                end
            end
            if (cmd.store_high)
            begin
                ref_high_reg <= byte_reg;
                phase_reg    <= 1'b1;
            end
            if (cmd.clear_phase)
            begin
                phase_reg <= 1'b0;
            end
            if (cmd.start_copy)
            begin
                copy_left_reg <= rlzd_pkg::LEN_W'(byte_reg & rlzd_pkg::LEN_MASK)
                               + rlzd_pkg::LEN_W'(rlzd_pkg::LEN_BIAS);
            end
            if (cmd.dict_write)
            begin
                wp_reg    <= wp_reg + AW'(1);
                count_reg <= count_reg + CW'(1);
                if (fill_reg != FILL_FULL)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
                if (cmd.emit_sel == rlzd_pkg::EMIT_COPY)
                begin
                    copy_left_reg <= copy_left_reg - rlzd_pkg::LEN_W'(1);
                end
            end
            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= data_byte;
            last_reg <= stream_end;
        end
        if (cmd.start_copy)
        begin
            copy_addr_reg <= {ref_high_reg, byte_reg[7:4]};
        end
        else if (cmd.dict_write && (cmd.emit_sel == rlzd_pkg::EMIT_COPY))
        begin
            copy_addr_reg <= copy_addr_reg + AW'(1);
        end
        // entries not yet written in this stream read as the preset text, or as zero past its end
        if (cmd.copy_read)
        begin
            hit_reg    <= (FW'(rel_addr) < fill_reg);
            preset_reg <= rlzd_pkg::preset_byte(copy_addr_reg);
        end
        if (cmd.emit)
        begin
            out_byte_reg <= emit_byte;
            status_reg   <= emit_status;
            run_last_reg <= cmd.emit_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_byte     = out_byte_reg;
    assign status       = status_reg;
    assign run_last     = run_last_reg;

endmodule

`default_nettype wire

### rtl/rtf_lzfu_decompressor_top.sv
// rtf_lzfu_decompressor_top: compressed rtf (lzfu) decompressor top level
// depends on rlzd_pkg, rlzd_ctrl, rlzd_datapath and rlzd_ram
//
// One compressed byte is taken per transfer; item_stall stays high until the
// last byte is done, so a new byte is not taken before then. The second byte
// of a reference starts a copy of L bytes (2 to 17); each copied byte passes
// through a read of the 4096-byte dictionary ram (ST_COPY_RD) and then a
// state that emits and writes it (ST_COPY_WR), and result stalls can hold the
// block in that state or in ST_DECODE. No clearing pass runs after reset or
// stream_start: a fill count tells which dictionary entries this stream has
// written, and the rest read as the preset text or zero. cfg_ready is
// always high; output_limit should be written only while the block is idle.
`default_nettype none

module rtf_lzfu_decompressor_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         stream_start,
    input  wire logic                         stream_end,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [7:0]                        out_byte,
    output logic [1:0]                        status,
    output logic                              run_last,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rlzd_pkg::LIMIT_W-1:0] cfg_data
);

    rlzd_pkg::cmd_t cmd;
    rlzd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    rlzd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    rlzd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .data_byte    (data_byte),
        .stream_start (stream_start),
        .stream_end   (stream_end),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .status       (status),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire

### rtl/rlzd_checker.sv
// rlzd_checker: port level assertions for the decompressor top level
// depends on rlzd_pkg; bound to rtf_lzfu_decompressor_top
`default_nettype none

module rlzd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] status,
    input wire logic       run_last
);

    // stalled result transfer holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(out_byte) && $stable(status) && $stable(run_last)))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == rlzd_pkg::STATUS_BYTE || status == rlzd_pkg::STATUS_LIMIT
                          || status == rlzd_pkg::STATUS_ZERO))
        else $error("unknown status code");

    a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != rlzd_pkg::STATUS_BYTE) |-> (out_byte == 8'h00))
        else $error("status result carries data");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != rlzd_pkg::STATUS_BYTE) |-> run_last)
        else $error("status result not last of run");

endmodule

bind rtf_lzfu_decompressor_top rlzd_checker u_rlzd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .status       (status),
    .run_last     (run_last)
);

`default_nettype wire

### tb/sv/tb_rtf_lzfu_decompressor_top.sv
// tb_rtf_lzfu_decompressor_top: self-checking bench for the lzfu decompressor, with a
// clocked driver and monitor around a bit-accurate decode model of its own
// depends on rlzd_pkg and rtf_lzfu_decompressor_top
`default_nettype none

module tb_rtf_lzfu_decompressor_top;

    localparam int PRESET_BYTES   = 207;
    localparam int RING_DEPTH     = 4096;
    localparam int COPY_BIAS      = 2;
    localparam int FLAG_COUNT     = 8;
    localparam logic [7:0] LEN_NIBBLE = 8'h0F;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_CAP      = 100;

    localparam logic [PRESET_BYTES*8-1:0] RTF_PRESET = {
        8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66, 8'h31, 8'h5C, 8'h61,
        8'h6E, 8'h73, 8'h69, 8'h5C, 8'h6D, 8'h61, 8'h63, 8'h5C,
        8'h64, 8'h65, 8'h66, 8'h66, 8'h30, 8'h5C, 8'h64, 8'h65,
        8'h66, 8'h74, 8'h61, 8'h62, 8'h37, 8'h32, 8'h30, 8'h7B,
        8'h5C, 8'h66, 8'h6F, 8'h6E, 8'h74, 8'h74, 8'h62, 8'h6C,
        8'h3B, 8'h7D, 8'h7B, 8'h5C, 8'h66, 8'h30, 8'h5C, 8'h66,
        8'h6E, 8'h69, 8'h6C, 8'h20, 8'h5C, 8'h66, 8'h72, 8'h6F,
        8'h6D, 8'h61, 8'h6E, 8'h20, 8'h5C, 8'h66, 8'h73, 8'h77,
        8'h69, 8'h73, 8'h73, 8'h20, 8'h5C, 8'h66, 8'h6D, 8'h6F,
        8'h64, 8'h65, 8'h72, 8'h6E, 8'h20, 8'h5C, 8'h66, 8'h73,
        8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h20, 8'h5C, 8'h66,
        8'h64, 8'h65, 8'h63, 8'h6F, 8'h72, 8'h20, 8'h4D, 8'h53,
        8'h20, 8'h53, 8'h61, 8'h6E, 8'h73, 8'h20, 8'h53, 8'h65,
        8'h72, 8'h69, 8'h66, 8'h53, 8'h79, 8'h6D, 8'h62, 8'h6F,
        8'h6C, 8'h41, 8'h72, 8'h69, 8'h61, 8'h6C, 8'h54, 8'h69,
        8'h6D, 8'h65, 8'h73, 8'h20, 8'h4E, 8'h65, 8'h77, 8'h20,
        8'h52, 8'h6F, 8'h6D, 8'h61, 8'h6E, 8'h43, 8'h6F, 8'h75,
        8'h72, 8'h69, 8'h65, 8'h72, 8'h7B, 8'h5C, 8'h63, 8'h6F,
        8'h6C, 8'h6F, 8'h72, 8'h74, 8'h62, 8'h6C, 8'h5C, 8'h72,
        8'h65, 8'h64, 8'h30, 8'h5C, 8'h67, 8'h72, 8'h65, 8'h65,
        8'h6E, 8'h30, 8'h5C, 8'h62, 8'h6C, 8'h75, 8'h65, 8'h30,
        8'h0D, 8'h0A, 8'h5C, 8'h70, 8'h61, 8'h72, 8'h20, 8'h5C,
        8'h70, 8'h61, 8'h72, 8'h64, 8'h5C, 8'h70, 8'h6C, 8'h61,
        8'h69, 8'h6E, 8'h5C, 8'h66, 8'h30, 8'h5C, 8'h66, 8'h73,
        8'h32, 8'h30, 8'h5C, 8'h62, 8'h5C, 8'h69, 8'h5C, 8'h75,
        8'h5C, 8'h74, 8'h61, 8'h62, 8'h5C, 8'h74, 8'h78
    };

    typedef struct packed {
        logic [7:0] byte_val;
        logic       start_flag;
        logic       end_flag;
    } comp_item_t;

    typedef struct packed {
        logic [7:0] res_byte;
        logic [1:0] res_status;
        logic       res_last;
    } decoded_t;

    typedef logic [rlzd_pkg::LIMIT_W-1:0] limit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         item_valid = 1'b0;
    logic                         item_stall;
    logic [7:0]                   data_byte = 8'h00;
    logic                         stream_start = 1'b0;
    logic                         stream_end = 1'b0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic [7:0]                   out_byte;
    logic [1:0]                   status;
    logic                         run_last;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [rlzd_pkg::LIMIT_W-1:0] cfg_data = '0;

    // decode model state
    logic [7:0]                   ring_model [0:RING_DEPTH-1];
    logic [11:0]                  wr_ptr;
    logic [7:0]                   flag_reg;
    logic [3:0]                   flags_rem;
    logic [7:0]                   ref_hi;
    logic                         ref_half;
    logic [rlzd_pkg::COUNT_WIDTH-1:0] emitted;
    logic                         stopped;
    logic [rlzd_pkg::LIMIT_W-1:0] limit_model;

    comp_item_t comp_bytes_q [$];
    decoded_t   decoded_due [$];
    decoded_t   step_out [$];
    comp_item_t next_item;
    decoded_t   want;

    int  mismatch_count = 0;
    int  items_made = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  quiet_cycles = 0;
    bit  send_idle_en = 1'b1;
    bit  recv_idle_en = 1'b1;
    logic [11:0] approx_wptr;

    rtf_lzfu_decompressor_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .data_byte    (data_byte),
        .stream_start (stream_start),
        .stream_end   (stream_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .status       (status),
        .run_last     (run_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    function automatic void restart_model();
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_model[i] = (i < PRESET_BYTES) ? RTF_PRESET[(PRESET_BYTES-1-i)*8 +: 8] : 8'h00;
        end
        wr_ptr    = 12'(PRESET_BYTES);
        flag_reg  = '0;
        flags_rem = '0;
        ref_hi    = '0;
        ref_half  = 1'b0;
        emitted   = '0;
        stopped   = 1'b0;
    endfunction

    function automatic bit emit_out(input logic [7:0] b);
        decoded_t r;
        if (emitted >= limit_model)
        begin
            r = '{8'h00, rlzd_pkg::STATUS_LIMIT, 1'b0};
            step_out.push_back(r);
            stopped = 1'b1;
            return 1'b0;
        end
        r = '{b, rlzd_pkg::STATUS_BYTE, 1'b0};
        step_out.push_back(r);
        ring_model[wr_ptr] = b;
        wr_ptr++;
        emitted++;
        return 1'b1;
    endfunction

    function automatic void shift_flag();
        flag_reg = flag_reg >> 1;
        if (flags_rem > 0)
        begin
            flags_rem--;
        end
    endfunction

    function automatic void lzfu_decode(input logic [7:0] b, input logic st, input logic en);
        logic [11:0] src;
        int          cnt;
        bit          ok;
        decoded_t    r;
        step_out.delete();
        if (st)
        begin
            restart_model();
        end
        if (!stopped)
        begin
            if (limit_model == '0)
            begin
                r = '{8'h00, rlzd_pkg::STATUS_ZERO, 1'b0};
                step_out.push_back(r);
                stopped = 1'b1;
            end
            else if (flags_rem == 0)
            begin
                flag_reg  = b;
                flags_rem = 4'(FLAG_COUNT);
                stopped   = en;
            end
            else if (!flag_reg[0])
            begin
                if (emit_out(b))
                begin
                    shift_flag();
                    stopped = en;
                end
            end
            else if (!ref_half)
            begin
                ref_hi   = b;
                ref_half = 1'b1;
                stopped  = en;
            end
            else
            begin
                ref_half = 1'b0;
                if (en)
                begin
                    stopped = 1'b1;
                end
                else
                begin
                    src = {ref_hi, b[7:4]};
                    cnt = int'(b & LEN_NIBBLE) + COPY_BIAS;
                    ok  = 1'b1;
                    for (int k = 0; k < cnt && ok; k++)
                    begin
                        ok = emit_out(ring_model[src]);
                        src++;
                    end
                    if (ok)
                    begin
                        shift_flag();
                    end
                end
            end
        end
        if (step_out.size() > 0)
        begin
            r = step_out.pop_back();
            r.res_last = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i])
        begin
            decoded_due.push_back(step_out[i]);
        end
    endfunction

    task automatic push_item(input logic [7:0] b, input logic st, input logic en,
                             input bit counted);
        comp_item_t it;
        it = '{b, st, en};
        comp_bytes_q.push_back(it);
        if (counted)
        begin
            items_made++;
        end
    endtask

    task automatic push_reference(input logic en);
        logic [11:0] src;
        logic [3:0]  len;
        case ($urandom_range(0, 3))
            0: src = 12'($urandom_range(0, RING_DEPTH - 1));
            1: src = 12'($urandom_range(0, PRESET_BYTES - 1));
            default: src = approx_wptr - 12'($urandom_range(1, 24));
        endcase
        len = 4'($urandom_range(0, 15));
        push_item(src[11:4], 1'b0, 1'b0, 1'b1);
        push_item({src[3:0], len}, 1'b0, en, 1'b1);
        approx_wptr += 12'(len) + 12'(COPY_BIAS);
    endtask

    // well-formed stream with random content and a random way of ending
    task automatic gen_stream(input int groups);
        logic [7:0] ctrl;
        int         nflags;
        int         ending;
        approx_wptr = 12'(PRESET_BYTES);
        ending = $urandom_range(0, 5);
        for (int g = 0; g < groups; g++)
        begin
            ctrl = 8'($urandom_range(0, 255));
            push_item(ctrl, g == 0, 1'b0, 1'b1);
            nflags = (ending == 5 && g == groups - 1) ? $urandom_range(0, 7) : FLAG_COUNT;
            for (int f = 0; f < nflags; f++)
            begin
                if (ctrl[f])
                begin
                    push_reference(1'b0);
                end
                else
                begin
                    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
                    approx_wptr++;
                end
            end
        end
        ctrl = 8'($urandom_range(0, 255));
        case (ending)
            1: push_item(ctrl, 1'b0, 1'b1, 1'b1);
            2:
            begin
                push_item(ctrl | 8'h01, 1'b0, 1'b0, 1'b1);
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
            end
            3:
            begin
                push_item(ctrl | 8'h01, 1'b0, 1'b0, 1'b1);
                push_reference(1'b1);
            end
            5: ;
            default:
            begin
                push_item(ctrl & 8'hFE, 1'b0, 1'b0, 1'b1);
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
            end
        endcase
        // trailing bytes after the end are dropped by the block
        if (ending != 5 && $urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
            end
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (comp_bytes_q.size() != 0 || item_valid || decoded_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [rlzd_pkg::LIMIT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        limit_model = v;
        @(negedge clk);
    endtask

    task automatic run_streams(input int count, input int max_groups);
        int goal;
        goal = items_made + count;
        while (items_made < goal)
        begin
            gen_stream($urandom_range(1, max_groups));
        end
    endtask

    // input side: one transfer per accepted item, random gaps between items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            data_byte    <= 8'h00;
            stream_start <= 1'b0;
            stream_end   <= 1'b0;
            gap_left     = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                lzfu_decode(data_byte, stream_start, stream_end);
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (send_idle_en && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(1, 19) - 1;
                    item_valid <= 1'b0;
                end
                else if (comp_bytes_q.size() > 0)
                begin
                    next_item    = comp_bytes_q.pop_front();
                    item_valid   <= 1'b1;
                    data_byte    <= next_item.byte_val;
                    stream_start <= next_item.start_flag;
                    stream_end   <= next_item.end_flag;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each result transfer, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (decoded_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result byte %h status %0d last %0b",
                                              out_byte, status, run_last));
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (out_byte !== want.res_byte)
                    begin
                        report_mismatch($sformatf("out_byte %h, want %h", out_byte,
                                                  want.res_byte));
                    end
                    if (status !== want.res_status)
                    begin
                        report_mismatch($sformatf("status %0d, want %0d", status,
                                                  want.res_status));
                    end
                    if (run_last !== want.res_last)
                    begin
                        report_mismatch($sformatf("run_last %0b, want %0b", run_last,
                                                  want.res_last));
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen  = hold_req;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (recv_idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_rtf_lzfu_decompressor_top: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        limit_model = '1;
        restart_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // literal, wrapping copy, overlapping copy, literals, control byte last
        push_item(8'h06, 1'b1, 1'b0, 1'b1);
        push_item(8'h00, 1'b0, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b0, 1'b1);
        push_item(8'hF0, 1'b0, 1'b0, 1'b1);
        push_item(8'h0C, 1'b0, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b0, 1'b1);
        push_item(8'h80, 1'b0, 1'b0, 1'b1);
        push_item(8'h01, 1'b0, 1'b0, 1'b1);
        push_item(8'h7F, 1'b0, 1'b0, 1'b1);
        push_item(8'h55, 1'b0, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b1, 1'b1);
        push_item(8'h12, 1'b0, 1'b0, 1'b1);
        // reference cut after its first byte
        push_item(8'h01, 1'b1, 1'b0, 1'b1);
        push_item(8'h00, 1'b0, 1'b1, 1'b1);
        // longest copy from offset zero, then reference cut after its second byte
        push_item(8'hFF, 1'b1, 1'b0, 1'b1);
        push_item(8'h00, 1'b0, 1'b0, 1'b1);
        push_item(8'h0F, 1'b0, 1'b0, 1'b1);
        push_item(8'h00, 1'b0, 1'b0, 1'b1);
        push_item(8'h0F, 1'b0, 1'b1, 1'b1);
        // literal marked last is still emitted, later bytes dropped
        push_item(8'h00, 1'b1, 1'b0, 1'b1);
        push_item(8'hA5, 1'b0, 1'b0, 1'b1);
        push_item(8'h5A, 1'b0, 1'b1, 1'b1);
        push_item(8'h33, 1'b0, 1'b0, 1'b1);
        push_item(8'h00, 1'b1, 1'b1, 1'b1);
        wait_drained();

        write_limit('1);
        run_streams(50, 2);
        hold_req++;
        wait_drained();

        write_limit(limit_t'($urandom_range(4, 40)));
        run_streams(30, 2);
        wait_drained();

        write_limit('0);
        run_streams(8, 1);
        wait_drained();

        write_limit(limit_t'(1));
        run_streams(10, 1);
        wait_drained();

        write_limit('1);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        run_streams(50, 2);
        wait_drained();

        if (mismatch_count == 0)
        begin
            $display("tb_rtf_lzfu_decompressor_top: clean");
        end
        else
        begin
            $display("tb_rtf_lzfu_decompressor_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/rlzd_pkg.sv
rtl/rlzd_ram.sv
rtl/rlzd_ctrl.sv
rtl/rlzd_datapath.sv
rtl/rtf_lzfu_decompressor_top.sv
rtl/rlzd_checker.sv
tb/sv/tb_rtf_lzfu_decompressor_top.sv
